// File: hdl/etc_pkg.sv
`timescale 1ns / 1ps

package etc_pkg;

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned DAYS_W = 16;
  localparam int unsigned REM_W = 6;

  localparam logic [EPOCH_W-1:0] SECS_PER_MIN = 32'd60;
  localparam logic [EPOCH_W-1:0] HOURS_PER_DAY = 32'd24;

  // Any 32-bit value divided by 60 is (x * RECIP_60) >> 37, and by 24 is
  // (x * RECIP_24) >> 36, with no correction step.
  localparam logic [EPOCH_W-1:0] RECIP_60 = 32'h8888_8889;
  localparam int unsigned RECIP_60_SHIFT = 37;
  localparam logic [EPOCH_W-1:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam int unsigned RECIP_24_SHIFT = 36;

  localparam logic [8:0] YEAR_DAYS = 9'd365;
  localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;

  localparam logic [1:0] EPOCH_MOD4 = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;
  localparam logic [6:0] MOD100_LAST = 7'd99;
  localparam logic [8:0] MOD400_LAST = 9'd399;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd11;
  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_DIV_STEP,
    CMD_SAVE_MINS,
    CMD_SAVE_HOURS,
    CMD_SAVE_DAYS,
    CMD_YEAR_STEP,
    CMD_MONTH_STEP,
    CMD_PUBLISH
  } dp_op_e;

  typedef enum logic {
    DIV_BY_60,
    DIV_BY_24
  } div_sel_e;

  typedef struct packed {
    dp_op_e   op;
    div_sel_e div_sel;
  } etc_cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
  } etc_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (month == MONTH_FEB && leap) begin
      len = FEB_LEAP_DAYS;
    end else if (month <= MONTH_DEC) begin
      len = MONTH_LEN[month];
    end
    return len;
  endfunction

endpackage

// File: hdl/etc_in_if.sv
`timescale 1ns / 1ps

interface etc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

// File: hdl/etc_out_if.sv
`timescale 1ns / 1ps

interface etc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] minute_of_hour;
  logic [4:0] hour_of_day;
  logic [4:0] day_of_month;
  logic [3:0] month_index;

  modport source (
    output valid, output minute_of_hour, output hour_of_day,
    output day_of_month, output month_index, input ready
  );
  modport sink (
    input valid, input minute_of_hour, input hour_of_day,
    input day_of_month, input month_index, output ready
  );
endinterface

// File: hdl/etc_datapath.sv
`timescale 1ns / 1ps

module etc_datapath
  import etc_pkg::*;
(
  input  logic                clk_i,
  input  etc_cmd_t            cmd_i,
  input  logic [EPOCH_W-1:0]  epoch_seconds_i,
  output etc_status_t         status_o,
  output logic [5:0]          minute_of_hour_o,
  output logic [4:0]          hour_of_day_o,
  output logic [4:0]          day_of_month_o,
  output logic [3:0]          month_index_o
);

  logic [EPOCH_W-1:0] num_q, num_d;
  logic [EPOCH_W-1:0] quot_q, quot_d;
  logic [5:0]         minute_q, minute_d;
  logic [4:0]         hour_q, hour_d;
  logic [DAYS_W-1:0]  days_q, days_d;
  logic [3:0]         month_q, month_d;
  logic [1:0]         mod4_q, mod4_d;
  logic [6:0]         mod100_q, mod100_d;
  logic [8:0]         mod400_q, mod400_d;
  logic [5:0]         out_min_q, out_min_d;
  logic [4:0]         out_hour_q, out_hour_d;
  logic [4:0]         out_day_q, out_day_d;
  logic [3:0]         out_month_q, out_month_d;

  logic [EPOCH_W-1:0]   recip;
  logic [2*EPOCH_W-1:0] product;
  logic [EPOCH_W-1:0]   quot_next;
  logic [EPOCH_W-1:0]   quot_times_div;
  logic [EPOCH_W-1:0]   rem_full;
  logic [REM_W-1:0]     rem;
  logic                 leap;
  logic [8:0]           year_len;
  logic [4:0]           mon_len;

  always_comb begin
    recip = (cmd_i.div_sel == DIV_BY_24) ? RECIP_24 : RECIP_60;
    product = (2*EPOCH_W)'(num_q) * (2*EPOCH_W)'(recip);
    quot_next = (cmd_i.div_sel == DIV_BY_24) ? EPOCH_W'(product >> RECIP_24_SHIFT) :
                                               EPOCH_W'(product >> RECIP_60_SHIFT);
    quot_times_div = (cmd_i.div_sel == DIV_BY_24) ? quot_q * HOURS_PER_DAY :
                                                    quot_q * SECS_PER_MIN;
    rem_full = num_q - quot_times_div;
    rem = rem_full[REM_W-1:0];
    leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
    year_len = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
    mon_len = month_len(month_q, leap);
    status_o.year_fits = (days_q < {{(DAYS_W-9){1'b0}}, year_len});
    status_o.month_fits = (month_q == MONTH_DEC) ||
                          (days_q < {{(DAYS_W-5){1'b0}}, mon_len});
  end

  always_comb begin
    num_d = num_q;
    quot_d = quot_q;
    minute_d = minute_q;
    hour_d = hour_q;
    days_d = days_q;
    month_d = month_q;
    mod4_d = mod4_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    out_min_d = out_min_q;
    out_hour_d = out_hour_q;
    out_day_d = out_day_q;
    out_month_d = out_month_q;
    unique case (cmd_i.op)
      CMD_IDLE: begin
      end
      CMD_LOAD: begin
        num_d = epoch_seconds_i;
      end
      CMD_DIV_STEP: begin
        quot_d = quot_next;
      end
      CMD_SAVE_MINS: begin
        num_d = quot_q;
      end
      CMD_SAVE_HOURS: begin
        minute_d = rem;
        num_d = quot_q;
      end
      CMD_SAVE_DAYS: begin
        hour_d = rem[4:0];
        days_d = quot_q[DAYS_W-1:0];
        month_d = MONTH_JAN;
        mod4_d = EPOCH_MOD4;
        mod100_d = EPOCH_MOD100;
        mod400_d = EPOCH_MOD400;
      end
      CMD_YEAR_STEP: begin
        days_d = days_q - {{(DAYS_W-9){1'b0}}, year_len};
        mod4_d = mod4_q + 2'd1;
        mod100_d = (mod100_q == MOD100_LAST) ? 7'd0 : mod100_q + 7'd1;
        mod400_d = (mod400_q == MOD400_LAST) ? 9'd0 : mod400_q + 9'd1;
      end
      CMD_MONTH_STEP: begin
        days_d = days_q - {{(DAYS_W-5){1'b0}}, mon_len};
        month_d = month_q + 4'd1;
      end
      CMD_PUBLISH: begin
        out_min_d = minute_q;
        out_hour_d = hour_q;
        out_day_d = days_q[4:0] + 5'd1;
        out_month_d = month_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quot_q <= quot_d;
    minute_q <= minute_d;
    hour_q <= hour_d;
    days_q <= days_d;
    month_q <= month_d;
    mod4_q <= mod4_d;
    mod100_q <= mod100_d;
    mod400_q <= mod400_d;
    out_min_q <= out_min_d;
    out_hour_q <= out_hour_d;
    out_day_q <= out_day_d;
    out_month_q <= out_month_d;
  end

  assign minute_of_hour_o = out_min_q;
  assign hour_of_day_o = out_hour_q;
  assign day_of_month_o = out_day_q;
  assign month_index_o = out_month_q;

endmodule

// File: hdl/etc_controller.sv
`timescale 1ns / 1ps

module etc_controller
  import etc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  etc_status_t status_i,
  output etc_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SAVE,
    S_YEAR,
    S_MONTH,
    S_PUBLISH
  } state_e;

  typedef enum logic [1:0] {
    STG_MIN,
    STG_HOUR,
    STG_DAY
  } stage_e;

  state_e                 state_q;
  stage_e                 stage_q;
  logic                   out_valid_q;
  logic                   publish;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign publish = (state_q == S_PUBLISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.op = CMD_IDLE;
    cmd_o.div_sel = (stage_q == STG_DAY) ? DIV_BY_24 : DIV_BY_60;
    unique case (state_q)
      S_IDLE:    cmd_o.op = in_valid_i ? CMD_LOAD : CMD_IDLE;
      S_DIV:     cmd_o.op = CMD_DIV_STEP;
      S_SAVE: begin
        unique case (stage_q)
          STG_MIN:  cmd_o.op = CMD_SAVE_MINS;
          STG_HOUR: cmd_o.op = CMD_SAVE_HOURS;
          STG_DAY:  cmd_o.op = CMD_SAVE_DAYS;
          default:  cmd_o.op = CMD_IDLE;
        endcase
      end
      S_YEAR:    cmd_o.op = status_i.year_fits ? CMD_IDLE : CMD_YEAR_STEP;
      S_MONTH:   cmd_o.op = status_i.month_fits ? CMD_IDLE : CMD_MONTH_STEP;
      S_PUBLISH: cmd_o.op = publish ? CMD_PUBLISH : CMD_IDLE;
      default:   cmd_o.op = CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stage_q <= STG_MIN;
      out_valid_q <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DIV;
            stage_q <= STG_MIN;
          end
        end
        S_DIV: begin
          state_q <= S_SAVE;
        end
        S_SAVE: begin
          unique case (stage_q)
            STG_MIN: begin
              stage_q <= STG_HOUR;
              state_q <= S_DIV;
            end
            STG_HOUR: begin
              stage_q <= STG_DAY;
              state_q <= S_DIV;
            end
            default: begin
              state_q <= S_YEAR;
            end
          endcase
        end
        S_YEAR: begin
          if (status_i.year_fits) begin
            state_q <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (status_i.month_fits) begin
            state_q <= S_PUBLISH;
          end
        end
        S_PUBLISH: begin
          if (publish) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_div_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |=> (state_q == S_SAVE))
    else $error("The divide step did not move on to the save step.");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && state_q == S_DIV))
    else $error("An accepted beat did not start the divide phase.");

  a_valid_from_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_PUBLISH))
    else $error("Output valid rose without a publish step.");

  a_day_save_to_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SAVE && stage_q == STG_DAY) |=> (state_q == S_YEAR))
    else $error("Day count was saved but the year walk did not start.");
`endif

endmodule

// File: hdl/epoch_to_calendar_fields.sv
`timescale 1ns / 1ps
// Channel   Role    Payload
// in_i      sink    epoch_seconds[31:0]
// out_o     source  minute_of_hour[5:0], hour_of_day[4:0], day_of_month[4:0],
//                   month_index[3:0]
//
// One beat is taken in at a time, and the next only after its publish step;
// the time to that step grows with Y, the number of whole years since 1970,
// and with M, the month index; Y + M never exceeds 146.
// Three divisions by 60, 60 and 24 use a reciprocal multiply and a
// remainder step; the year walk takes off one year per step and the month
// walk one month per step, each ending on a step that sees that it is done.
// The result sits in an output register, so a stalled output holds only the
// publish step of the next beat.
// Reset clears the controller and the output valid; no clearing pass is run.

module epoch_to_calendar_fields
  import etc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  etc_in_if.sink    in_i,
  etc_out_if.source out_o
);

  etc_cmd_t    cmd;
  etc_status_t status;

  etc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  etc_datapath u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .epoch_seconds_i  (in_i.epoch_seconds),
    .status_o         (status),
    .minute_of_hour_o (out_o.minute_of_hour),
    .hour_of_day_o    (out_o.hour_of_day),
    .day_of_month_o   (out_o.day_of_month),
    .month_index_o    (out_o.month_index)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import etc_pkg::*;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
  } calendar_t;

  localparam int unsigned SECS_IN_DAY = 86400;
  localparam int unsigned LAST_FULL_DAY = 49709;
  localparam int unsigned MAX_GAP = 10;
  localparam int unsigned DRAIN_CYCLES = 260;

  localparam int unsigned COMMON_MONTH_DAYS [12] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  localparam logic [31:0] CORNER_EPOCHS [21] = '{
    32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd68169600, 32'd94694399, 32'd946684799, 32'd951782400, 32'd951868800,
    32'd2147483647, 32'd2147483648, 32'd4102444799, 32'd4107456000,
    32'd4107542400, 32'd4133980799, 32'hAAAA_AAAA, 32'h5555_5555,
    32'hFFFF_FFFF
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  etc_in_if  in_bus ();
  etc_out_if out_bus ();

  epoch_to_calendar_fields dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  calendar_t pending_dates[$];
  int unsigned mismatch_count = 0;
  bit no_idle = 1'b0;

  always #5 clk_i = ~clk_i;

  function automatic bit is_leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic calendar_t calendar_of(input logic [31:0] secs);
    int unsigned total_min;
    int unsigned total_hr;
    int unsigned day_left;
    int unsigned yr;
    int unsigned mon;
    int unsigned year_len;
    int unsigned mon_len;
    calendar_t c;
    total_min = secs / 60;
    total_hr = total_min / 60;
    day_left = total_hr / 24;
    yr = 1970;
    year_len = is_leap_year(yr) ? 366 : 365;
    while (day_left >= year_len) begin
      day_left -= year_len;
      yr++;
      year_len = is_leap_year(yr) ? 366 : 365;
    end
    mon = 0;
    mon_len = COMMON_MONTH_DAYS[0];
    while (mon < 11 && day_left >= mon_len) begin
      day_left -= mon_len;
      mon++;
      mon_len = (mon == 1 && is_leap_year(yr)) ? 29 : COMMON_MONTH_DAYS[mon];
    end
    c.minute = 6'(total_min % 60);
    c.hour = 5'(total_hr % 24);
    c.day = 5'(day_left + 1);
    c.month = 4'(mon);
    return c;
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_epoch(input logic [31:0] secs);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.epoch_seconds <= secs;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_dates.push_back(calendar_of(secs));
    @(negedge clk_i);
  endtask

  task automatic test_corner_instants();
    foreach (CORNER_EPOCHS[i]) send_epoch(CORNER_EPOCHS[i]);
  endtask

  task automatic test_uniform_epochs(input int unsigned count);
    repeat (count) send_epoch($urandom());
  endtask

  task automatic test_day_boundaries(input int unsigned count);
    longint unsigned secs;
    int unsigned pick;
    repeat (count) begin
      secs = longint'($urandom_range(0, LAST_FULL_DAY)) * SECS_IN_DAY;
      pick = $urandom_range(0, 3);
      if (pick == 1) begin
        secs += SECS_IN_DAY - 1;
      end else if (pick == 2) begin
        secs += $urandom_range(0, SECS_IN_DAY - 1);
      end else if (pick == 3 && secs != 0) begin
        secs -= 1;
      end
      send_epoch(32'(secs));
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    no_idle = 1'b1;
    repeat (count) send_epoch($urandom());
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    calendar_t want;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %0d/%0d %0d:%0d", $time,
                 out_bus.month_index, out_bus.day_of_month, out_bus.hour_of_day,
                 out_bus.minute_of_hour);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        compare_field("minute_of_hour", want.minute, out_bus.minute_of_hour);
        compare_field("hour_of_day", want.hour, out_bus.hour_of_day);
        compare_field("day_of_month", want.day, out_bus.day_of_month);
        compare_field("month_index", want.month, out_bus.month_index);
      end
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.epoch_seconds = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_corner_instants();
    test_uniform_epochs(1000);
    test_day_boundaries(600);
    test_back_to_back(150);
    in_bus.valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("%0t: timeout with %0d beats outstanding", $time, pending_dates.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: epoch_to_calendar_fields.f
hdl/etc_pkg.sv
hdl/etc_in_if.sv
hdl/etc_out_if.sv
hdl/etc_datapath.sv
hdl/etc_controller.sv
hdl/epoch_to_calendar_fields.sv
tb/sv/testbench.sv
